// ===== rtl/pwcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwcs_pkg
// Shared types and constants for the pulse-width command sender.
// ----------------------------------------------------------------------------
package pwcs_pkg;

  localparam int unsigned TICK_W = 10;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned REP_W  = 4;
  localparam int unsigned BIT_W  = 3;
  localparam int unsigned IDX_W  = 3;

  localparam logic [TICK_W-1:0] START_RST    = TICK_W'(30);
  localparam logic [TICK_W-1:0] SHORT_RST    = TICK_W'(10);
  localparam logic [TICK_W-1:0] LONG_RST     = TICK_W'(20);
  localparam logic [TICK_W-1:0] END_LOW_RST  = TICK_W'(30);
  localparam logic [TICK_W-1:0] END_HIGH_RST = TICK_W'(600);
  localparam logic [REP_W-1:0]  REPEAT_RST   = REP_W'(8);
  localparam logic [BIT_W-1:0]  LAST_BIT     = BIT_W'(CMD_W - 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ABORT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_LOAD,
    KIND_ABORT,
    KIND_HOLD
  } kind_e;

  typedef enum logic [IDX_W-1:0] {
    REG_START    = 3'd0,
    REG_SHORT    = 3'd1,
    REG_LONG     = 3'd2,
    REG_END_LOW  = 3'd3,
    REG_END_HIGH = 3'd4,
    REG_REPEAT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_EOD_LOW,
    PH_EOD_HIGH
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [CMD_W-1:0] command;
    logic             mode;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

  // zero-length segment lasts one tick
  function automatic logic [TICK_W-1:0] seg_len(input logic [TICK_W-1:0] r);
    seg_len = (r == '0) ? TICK_W'(1) : r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pwcs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwcs_front
// Decodes an incoming word into an operation kind and mode-control flag.
// ----------------------------------------------------------------------------
module pwcs_front import pwcs_pkg::*; (
  input  wire logic [1:0]       operation_i,
  input  wire logic [CMD_W-1:0] command_i,
  output item_t                 item_o
);

  always_comb begin
    item_o.command = command_i;
    // address 5 or 7 in bits 7..5: bits 7 and 5 set, bit 6 ignored
    item_o.mode    = command_i[7] & command_i[5];
    unique case (operation_i)
      OP_TICK:  item_o.kind = KIND_TICK;
      OP_LOAD:  item_o.kind = KIND_LOAD;
      OP_ABORT: item_o.kind = KIND_ABORT;
      default:  item_o.kind = KIND_HOLD;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pwcs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwcs_queue
// Two-word queue between the decoder and the waveform engine.
// ----------------------------------------------------------------------------
module pwcs_queue import pwcs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      data_o,
  output logic       empty_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pwcs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwcs_back
// Waveform engine: configuration registers, segment sequencer and a
// two-word result buffer.
// ----------------------------------------------------------------------------
module pwcs_back import pwcs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [TICK_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  input  wire item_t             in_item_i,
  output logic                   in_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output result_t                res_o
);

  // configuration
  logic [TICK_W-1:0] start_q, short_q, long_q, end_low_q, end_high_q;
  logic [REP_W-1:0]  repeat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= START_RST;
      short_q    <= SHORT_RST;
      long_q     <= LONG_RST;
      end_low_q  <= END_LOW_RST;
      end_high_q <= END_HIGH_RST;
      repeat_q   <= REPEAT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START:    start_q    <= cfg_data_i;
        REG_SHORT:    short_q    <= cfg_data_i;
        REG_LONG:     long_q     <= cfg_data_i;
        REG_END_LOW:  end_low_q  <= cfg_data_i;
        REG_END_HIGH: end_high_q <= cfg_data_i;
        REG_REPEAT:   repeat_q   <= cfg_data_i[REP_W-1:0];
        default:      ;
      endcase
    end
  end

  // result buffer
  result_t    obuf_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       out_full, fire, res_pop;
  result_t    res_d;

  assign out_full = (ocnt_q == 2'd2);
  assign fire     = in_valid_i & ~out_full;
  assign in_pop_o = fire;
  assign empty_o  = (ocnt_q == 2'd0);
  assign res_pop  = pop_i & ~empty_o;
  assign res_o    = obuf_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (fire) owr_q <= ~owr_q;
      if (res_pop) ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + 2'(fire) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obuf_q[owr_q] <= res_d;
    end
  end

  // sequencer
  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d, tick_dec;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [CMD_W-1:0]  shift_q, shift_d, shift_rot;
  logic [REP_W-1:0]  frames_q, frames_d, frames_dec;
  logic              line_q, line_d;
  logic              done, rej, one_cur, one_nxt;

  assign tick_dec   = tick_q - TICK_W'(1);
  assign frames_dec = frames_q - REP_W'(1);
  assign shift_rot  = {shift_q[CMD_W-2:0], shift_q[CMD_W-1]};
  assign one_cur    = shift_q[CMD_W-1];
  assign one_nxt    = shift_q[CMD_W-2];

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    frames_d = frames_q;
    line_d   = line_q;
    done     = 1'b0;
    rej      = 1'b0;
    unique case (in_item_i.kind)
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          tick_d = tick_dec;
          if (tick_dec == '0) begin
            unique case (phase_q)
              PH_START: begin
                bit_d   = '0;
                phase_d = PH_BIT_LOW;
                line_d  = 1'b0;
                tick_d  = seg_len(one_cur ? short_q : long_q);
              end
              PH_BIT_LOW: begin
                phase_d = PH_BIT_HIGH;
                line_d  = 1'b1;
                tick_d  = seg_len(one_cur ? long_q : short_q);
              end
              PH_BIT_HIGH: begin
                shift_d = shift_rot;
                line_d  = 1'b0;
                if (bit_q == LAST_BIT) begin
                  bit_d   = '0;
                  phase_d = PH_EOD_LOW;
                  tick_d  = seg_len(end_low_q);
                end else begin
                  bit_d   = bit_q + BIT_W'(1);
                  phase_d = PH_BIT_LOW;
                  tick_d  = seg_len(one_nxt ? short_q : long_q);
                end
              end
              PH_EOD_LOW: begin
                phase_d = PH_EOD_HIGH;
                line_d  = 1'b1;
                tick_d  = seg_len(end_high_q);
              end
              default: begin
                frames_d = frames_dec;
                line_d   = 1'b1;
                if (frames_dec == '0) begin
                  phase_d = PH_IDLE;
                  tick_d  = '0;
                  done    = 1'b1;
                end else begin
                  phase_d = PH_START;
                  tick_d  = seg_len(start_q);
                end
              end
            endcase
          end
        end
      end
      KIND_LOAD: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          shift_d  = in_item_i.command;
          bit_d    = '0;
          frames_d = (in_item_i.mode && repeat_q != '0) ? repeat_q : REP_W'(1);
          phase_d  = PH_START;
          line_d   = 1'b1;
          tick_d   = seg_len(start_q);
        end
      end
      KIND_ABORT: begin
        phase_d  = PH_IDLE;
        tick_d   = '0;
        bit_d    = '0;
        frames_d = '0;
        line_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d.line_level = line_d;
    res_d.busy_res   = (phase_d != PH_IDLE);
    res_d.frame_done = done;
    res_d.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
      frames_q <= '0;
      line_q   <= 1'b0;
    end else if (fire) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      frames_q <= frames_d;
      line_q   <= line_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pulse_width_command_sender.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_command_sender
// One-wire pulse-width coded command sender: decoder, two-word queue and
// waveform engine with a two-word result buffer.
// ----------------------------------------------------------------------------
// channel   | handshake              | payload
// input     | push, full             | operation_i, command_i
// result    | pop, empty             | line_level_o, busy_res_o, frame_done_o,
//           |                        | rejected_o
// config    | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the result buffer has room; the engine
// updates its state for each word. With nothing waiting, a word is registered
// in the queue, then its result in the buffer that drives the result ports.
// Reset loads the register defaults and leaves the line low and idle.
// A stalled result side backs up through the result buffer and the queue.
// ----------------------------------------------------------------------------
module pulse_width_command_sender import pwcs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        operation_i,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic              pop,
  output logic                   empty,
  output logic                   line_level_o,
  output logic                   busy_res_o,
  output logic                   frame_done_o,
  output logic                   rejected_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [TICK_W-1:0] cfg_data_i
);

  item_t   dec_item, q_item;
  logic    q_empty, q_pop;
  result_t res;

  assign cfg_ready_o = 1'b1;

  pwcs_front u_front (
    .operation_i (operation_i),
    .command_i   (command_i),
    .item_o      (dec_item)
  );

  pwcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  pwcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (~q_empty),
    .in_item_i   (q_item),
    .in_pop_o    (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign line_level_o = res.line_level;
  assign busy_res_o   = res.busy_res;
  assign frame_done_o = res.frame_done;
  assign rejected_o   = res.rejected;

endmodule
`default_nettype wire
